FILE: rtl/core/cscan_pkg.sv
// Shared types, constants and helpers for the C-SCAN seek scheduler.
// Used by cscan_ctrl, cscan_dp and cscan_disk_seek_scheduler; no dependencies.
package cscan_pkg;

  localparam int QDEPTH     = 16;
  localparam int TRACK_BITS = 12;
  localparam int QIDX_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);
  localparam int SEEK_W     = 24;
  localparam int TC_W       = TRACK_BITS + 1;
  localparam int TC_RESET   = 200;
  localparam int TC_MIN     = 2;
  localparam int TC_MAX     = 1 << TRACK_BITS;

  localparam logic ACT_ADD = 1'b0;
  localparam logic ACT_RUN = 1'b1;

  localparam logic REG_TRACK_COUNT = 1'b0;

  typedef logic [TRACK_BITS-1:0] track_t;
  typedef logic [QCNT_W-1:0]     qcnt_t;
  typedef logic [SEEK_W-1:0]     seek_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HEAD,
    ST_LOW,
    ST_ZERO,
    ST_TOP,
    ST_HIGH
  } state_t;

  typedef enum logic [2:0] {
    SEL_HEAD,
    SEL_LOW,
    SEL_ZERO,
    SEL_TOP,
    SEL_HIGH
  } sel_t;

  typedef struct packed {
    logic insert;
    logic start;
    logic scan;
    logic set_split;
    logic rd_prev;
    logic emit;
    sel_t sel;
    logic last;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_stop;
    logic idx_zero;
    logic idx_one;
    logic no_high;
    logic high_end;
    logic out_free;
  } dp_stat_t;

  function automatic track_t clamp_track(input track_t v, input track_t top);
    clamp_track = (v > top) ? top : v;
  endfunction

endpackage

FILE: rtl/core/cscan_ctrl.sv
// Sequencer for the C-SCAN seek scheduler: scan for the split, then walk the path.
// Depends on cscan_pkg; drives cscan_dp through dp_cmd_t and reads dp_stat_t.
module cscan_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_action,
  output logic               in_tready,
  input  cscan_pkg::dp_stat_t stat,
  output cscan_pkg::dp_cmd_t  cmd
);

  cscan_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cscan_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cscan_pkg::ST_IDLE: begin
        if (in_tvalid && in_action == cscan_pkg::ACT_RUN) state_nxt = cscan_pkg::ST_SCAN;
      end
      cscan_pkg::ST_SCAN: begin
        if (stat.scan_stop) state_nxt = cscan_pkg::ST_HEAD;
      end
      cscan_pkg::ST_HEAD: begin
        if (stat.out_free) begin
          state_nxt = stat.idx_zero ? cscan_pkg::ST_ZERO : cscan_pkg::ST_LOW;
        end
      end
      cscan_pkg::ST_LOW: begin
        if (stat.out_free && stat.idx_one) state_nxt = cscan_pkg::ST_ZERO;
      end
      cscan_pkg::ST_ZERO: begin
        if (stat.out_free) state_nxt = cscan_pkg::ST_TOP;
      end
      cscan_pkg::ST_TOP: begin
        if (stat.out_free) begin
          state_nxt = stat.no_high ? cscan_pkg::ST_IDLE : cscan_pkg::ST_HIGH;
        end
      end
      cscan_pkg::ST_HIGH: begin
        if (stat.out_free && stat.high_end) state_nxt = cscan_pkg::ST_IDLE;
      end
      default: state_nxt = cscan_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    cmd           = '0;
    cmd.sel       = cscan_pkg::SEL_HEAD;
    cmd.rd_prev   = 1'b1;
    unique case (state_r)
      cscan_pkg::ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.insert = in_tvalid && in_action == cscan_pkg::ACT_ADD;
        cmd.start  = in_tvalid && in_action == cscan_pkg::ACT_RUN;
      end
      cscan_pkg::ST_SCAN: begin
        cmd.rd_prev   = 1'b0;
        cmd.scan      = !stat.scan_stop;
        cmd.set_split = stat.scan_stop;
      end
      cscan_pkg::ST_HEAD: begin
        cmd.emit = stat.out_free;
        cmd.sel  = cscan_pkg::SEL_HEAD;
      end
      cscan_pkg::ST_LOW: begin
        cmd.emit = stat.out_free;
        cmd.sel  = cscan_pkg::SEL_LOW;
      end
      cscan_pkg::ST_ZERO: begin
        cmd.emit = stat.out_free;
        cmd.sel  = cscan_pkg::SEL_ZERO;
      end
      cscan_pkg::ST_TOP: begin
        cmd.emit   = stat.out_free;
        cmd.sel    = cscan_pkg::SEL_TOP;
        cmd.last   = stat.no_high;
        cmd.finish = stat.out_free && stat.no_high;
      end
      cscan_pkg::ST_HIGH: begin
        cmd.emit   = stat.out_free;
        cmd.sel    = cscan_pkg::SEL_HIGH;
        cmd.last   = stat.high_end;
        cmd.finish = stat.out_free && stat.high_end;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

FILE: rtl/core/cscan_dp.sv
// Datapath for the C-SCAN seek scheduler: sorted request store, walk index,
// seek accumulator and output beat register. Depends on cscan_pkg.
module cscan_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cscan_pkg::dp_cmd_t    cmd,
  output cscan_pkg::dp_stat_t   stat,
  input  cscan_pkg::track_t     in_req,
  input  cscan_pkg::track_t     in_head,
  input  cscan_pkg::track_t     top,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output cscan_pkg::track_t     out_trk,
  output cscan_pkg::seek_t      out_seek,
  output logic                  out_last,
  output logic                  out_ovf
);

  cscan_pkg::track_t store_r   [cscan_pkg::QDEPTH];
  cscan_pkg::track_t store_nxt [cscan_pkg::QDEPTH];
  logic [cscan_pkg::QDEPTH-1:0] gt;

  cscan_pkg::qcnt_t  count_r, count_nxt;
  logic              ovf_r, ovf_nxt;
  cscan_pkg::track_t head_r, pos_r;
  cscan_pkg::qcnt_t  idx_r, idx_nxt, split_r;
  cscan_pkg::seek_t  seek_r;

  logic              out_valid_r;
  cscan_pkg::track_t out_trk_r;
  cscan_pkg::seek_t  out_seek_r;
  logic              out_last_r, out_ovf_r;

  cscan_pkg::qcnt_t  rd_addr;
  cscan_pkg::track_t rd_val;
  cscan_pkg::track_t trk;
  cscan_pkg::track_t move_dist;
  logic [cscan_pkg::SEEK_W:0] seek_sum;
  cscan_pkg::seek_t  seek_new;
  logic              full;

  // sorted insert: entries above the new track move up one place
  always_comb begin
    for (int k = 0; k < cscan_pkg::QDEPTH; k++) begin
      gt[k] = (cscan_pkg::QCNT_W'(k) < count_r) && (store_r[k] > in_req);
    end
    store_nxt[0] = (gt[0] || count_r == '0) ? in_req : store_r[0];
    for (int k = 1; k < cscan_pkg::QDEPTH; k++) begin
      if (gt[k-1]) begin
        store_nxt[k] = store_r[k-1];
      end else if (gt[k] || cscan_pkg::QCNT_W'(k) == count_r) begin
        store_nxt[k] = in_req;
      end else begin
        store_nxt[k] = store_r[k];
      end
    end
  end

  assign full = count_r >= cscan_pkg::QCNT_W'(cscan_pkg::QDEPTH);

  always_ff @(posedge clk) begin
    if (cmd.insert && !full) begin
      store_r <= store_nxt;
    end
  end

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (cmd.insert) begin
      if (full) ovf_nxt = 1'b1;
      else      count_nxt = count_r + 1'b1;
    end
    if (cmd.finish) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  assign rd_addr = cmd.rd_prev ? (idx_r - 1'b1) : idx_r;
  assign rd_val  = cscan_pkg::clamp_track(store_r[rd_addr[cscan_pkg::QIDX_W-1:0]], top);

  always_comb begin
    unique case (cmd.sel)
      cscan_pkg::SEL_HEAD: trk = head_r;
      cscan_pkg::SEL_ZERO: trk = '0;
      cscan_pkg::SEL_TOP:  trk = top;
      default:             trk = rd_val;
    endcase
    move_dist = (cmd.sel == cscan_pkg::SEL_TOP) ? trk : (pos_r - trk);
    seek_sum  = {1'b0, seek_r} + (cscan_pkg::SEEK_W+1)'(move_dist);
    if (cmd.sel == cscan_pkg::SEL_HEAD) begin
      seek_new = '0;
    end else if (seek_sum[cscan_pkg::SEEK_W]) begin
      seek_new = '1;
    end else begin
      seek_new = seek_sum[cscan_pkg::SEEK_W-1:0];
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.start) begin
      idx_nxt = '0;
    end else if (cmd.scan) begin
      idx_nxt = idx_r + 1'b1;
    end else if (cmd.emit) begin
      case (cmd.sel) inside
        cscan_pkg::SEL_LOW, cscan_pkg::SEL_HIGH: idx_nxt = idx_r - 1'b1;
        cscan_pkg::SEL_ZERO:                     idx_nxt = count_r;
        default:                                 idx_nxt = idx_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.start)     head_r  <= cscan_pkg::clamp_track(in_head, top);
    if (cmd.set_split) split_r <= idx_r;
    if (cmd.emit) begin
      pos_r      <= trk;
      seek_r     <= seek_new;
      out_trk_r  <= trk;
      out_seek_r <= seek_new;
      out_last_r <= cmd.last;
      out_ovf_r  <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.scan_stop = (idx_r == count_r) || (rd_val > head_r);
  assign stat.idx_zero  = idx_r == '0;
  assign stat.idx_one   = idx_r == cscan_pkg::QCNT_W'(1);
  assign stat.no_high   = count_r == split_r;
  assign stat.high_end  = idx_r == (split_r + 1'b1);
  assign stat.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_trk    = out_trk_r;
  assign out_seek   = out_seek_r;
  assign out_last   = out_last_r;
  assign out_ovf    = out_ovf_r;

endmodule

FILE: rtl/core/cscan_disk_seek_scheduler.sv
// C-SCAN disk seek scheduler top level: stream ports, APB register, ctrl + datapath.
// Depends on cscan_pkg, cscan_ctrl and cscan_dp.
// Flow: a run beat is accepted, then the sorted store is scanned for the split, then
// count+3 path beats follow, one per cycle when out_tready stays high; the walk over
// the store through its single read port sets this rate.
// Reset (rst_n low, synchronous): request count and overflow flag clear, track_count = 200.
module cscan_disk_seek_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [11:0] request_track, [23:12] head_track
  input  logic        in_tuser,   // [0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [11:0] path_track, [35:12] seek_so_far, [39:36] zero
  output logic        out_tlast,  // last_of_path
  output logic        out_tuser,  // [0] queue_overflow
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [cscan_pkg::TC_W-1:0] tc_r;
  logic [cscan_pkg::TC_W-1:0] tc_c;
  cscan_pkg::track_t          top;
  cscan_pkg::dp_cmd_t         cmd;
  cscan_pkg::dp_stat_t        stat;
  cscan_pkg::track_t          out_trk;
  cscan_pkg::seek_t           out_seek;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_r <= cscan_pkg::TC_W'(cscan_pkg::TC_RESET);
    end else if (psel && penable && pwrite && pready && paddr[2] == cscan_pkg::REG_TRACK_COUNT) begin
      tc_r <= pwdata[cscan_pkg::TC_W-1:0];
    end
  end

  assign prdata = (paddr[2] == cscan_pkg::REG_TRACK_COUNT) ? {{(32-cscan_pkg::TC_W){1'b0}}, tc_r}
                                                          : 32'd0;

  always_comb begin
    if (tc_r < cscan_pkg::TC_W'(cscan_pkg::TC_MIN)) begin
      tc_c = cscan_pkg::TC_W'(cscan_pkg::TC_MIN);
    end else if (tc_r > cscan_pkg::TC_W'(cscan_pkg::TC_MAX)) begin
      tc_c = cscan_pkg::TC_W'(cscan_pkg::TC_MAX);
    end else begin
      tc_c = tc_r;
    end
  end

  assign top = cscan_pkg::TRACK_BITS'(tc_c - 1'b1);

  cscan_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_action (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cscan_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_req     (in_tdata[11:0]),
    .in_head    (in_tdata[23:12]),
    .top        (top),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_trk    (out_trk),
    .out_seek   (out_seek),
    .out_last   (out_tlast),
    .out_ovf    (out_tuser)
  );

  assign out_tdata = {4'b0000, out_seek, out_trk};

endmodule

FILE: bench/tb_cscan_disk_seek_scheduler.sv
// Testbench for cscan_disk_seek_scheduler: drives request and run beats, predicts each
// C-SCAN service path in a scoreboard class and checks every path beat against it.
// Depends on cscan_pkg and the scheduler RTL.
`timescale 1ns / 100ps

module tb_cscan_disk_seek_scheduler;
  import cscan_pkg::*;

  typedef struct {
    track_t     trk;
    seek_t      seek;
    logic       last;
    logic       ovf;
  } path_point_t;

  class cscan_path_tracker;
    logic [TC_W-1:0] track_count;
    track_t          pending_reqs[$];
    logic            dropped;
    path_point_t     path_due[$];
    int              mismatches;

    function new();
      track_count = TC_W'(TC_RESET);
      dropped = 1'b0;
      mismatches = 0;
    endfunction

    function seek_t seek_add(seek_t s, int unsigned d);
      int unsigned sum;
      sum = s + d;
      return (sum > 32'h00FF_FFFF) ? '1 : seek_t'(sum);
    endfunction

    function void push_point(int unsigned trk, seek_t seek);
      path_point_t p;
      p.trk  = track_t'(trk);
      p.seek = seek;
      p.last = 1'b0;
      p.ovf  = dropped;
      path_due.push_back(p);
    endfunction

    function void note_beat(logic act, track_t req, track_t hd);
      int unsigned tc, top, head, pos, split;
      int unsigned tracks[$];
      seek_t seek;
      if (act == ACT_ADD) begin
        if (pending_reqs.size() < QDEPTH) pending_reqs.push_back(req);
        else dropped = 1'b1;
        return;
      end
      tc = track_count;
      if (tc < TC_MIN) tc = TC_MIN;
      if (tc > TC_MAX) tc = TC_MAX;
      top = tc - 1;
      head = (hd > top) ? top : hd;
      foreach (pending_reqs[i]) tracks.push_back((pending_reqs[i] > top) ? top : pending_reqs[i]);
      tracks.sort();
      split = 0;
      while (split < tracks.size() && tracks[split] <= head) split++;
      seek = '0;
      pos = head;
      push_point(head, seek);
      for (int i = split; i > 0; i--) begin
        seek = seek_add(seek, pos - tracks[i-1]);
        pos = tracks[i-1];
        push_point(pos, seek);
      end
      seek = seek_add(seek, pos);
      push_point(0, seek);
      seek = seek_add(seek, top);
      pos = top;
      push_point(top, seek);
      for (int i = tracks.size(); i > split; i--) begin
        seek = seek_add(seek, pos - tracks[i-1]);
        pos = tracks[i-1];
        push_point(pos, seek);
      end
      path_due[path_due.size()-1].last = 1'b1;
      pending_reqs.delete();
      dropped = 1'b0;
    endfunction

    function void check_path_point(track_t trk, seek_t seek, logic last, logic ovf);
      path_point_t want;
      if (path_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected path beat: track %0d seek %0d last %0b ovf %0b",
                   trk, seek, last, ovf);
        return;
      end
      want = path_due.pop_front();
      if (want.trk !== trk || want.seek !== seek || want.last !== last || want.ovf !== ovf) begin
        mismatches++;
        if (mismatches <= 10)
          $display("path mismatch: got track %0d seek %0d last %0b ovf %0b, want %0d %0d %0b %0b",
                   trk, seek, last, ovf, want.trk, want.seek, want.last, want.ovf);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;  // [11:0] request_track, [23:12] head_track
  logic        in_tuser   = 1'b0; // [0] action
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;        // [11:0] path_track, [35:12] seek_so_far, [39:36] zero
  logic        out_tlast;
  logic        out_tuser;        // [0] queue_overflow
  logic        psel       = 1'b0;
  logic        penable    = 1'b0;
  logic        pwrite     = 1'b0;
  logic [2:0]  paddr      = '0;
  logic [31:0] pwdata     = '0;
  logic [31:0] prdata;
  logic        pready;

  cscan_path_tracker board = new();
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit long_hold      = 1'b0;
  bit hold_taken     = 1'b0;

  cscan_disk_seek_scheduler u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      board.note_beat(in_tuser, in_tdata[11:0], in_tdata[23:12]);
    if (rst_n && out_tvalid && out_tready)
      board.check_path_point(out_tdata[11:0], out_tdata[35:12], out_tlast, out_tuser);
  end

  // receiver: random stalls, plus one long hold-off once the sender offers beats
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold && !hold_taken && in_tvalid) begin
        hold_taken = 1'b1;
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
        @(posedge clk);
      end
    end
  end

  task automatic send_beat(input logic act, input track_t req, input track_t hd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {hd, req};
    in_tuser  <= act;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic settle_path();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.path_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_track_count(input logic [TC_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(REG_TRACK_COUNT) << 2;
    pwdata  <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.track_count = val;
  endtask

  function automatic track_t pick_track(input int unsigned top);
    case ($urandom_range(7))
      0:       return '0;
      1:       return track_t'(top);
      2, 3:    return track_t'($urandom);
      default: return track_t'($urandom_range(top));
    endcase
  endfunction

  task automatic run_batch(input int n_adds, input int unsigned top);
    track_t hd;
    hd = pick_track(top);
    for (int i = 0; i < n_adds; i++)
      send_beat(ACT_ADD, ($urandom_range(7) == 0) ? hd : pick_track(top), track_t'($urandom));
    send_beat(ACT_RUN, track_t'($urandom), hd);
  endtask

  task automatic random_block(input logic [TC_W-1:0] tc, input int beats);
    int unsigned top;
    int sent, n;
    settle_path();
    write_track_count(tc);
    top = (tc < TC_MIN) ? TC_MIN - 1 : (tc > TC_MAX) ? TC_MAX - 1 : tc - 1;
    sent = 0;
    while (sent < beats) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(QDEPTH + 4, QDEPTH + 1)
                                   : $urandom_range(QDEPTH);
      run_batch(n, top);
      sent += n + 1;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct  = 12;
    recv_stall_pct = 57;
    // empty store
    send_beat(ACT_RUN, 12'hFFF, 12'd0);
    // request past the top track, request equal to head
    send_beat(ACT_ADD, 12'd4095, 12'd0);
    send_beat(ACT_ADD, 12'd50, 12'hFFF);
    send_beat(ACT_ADD, 12'd120, 12'd0);
    send_beat(ACT_RUN, 12'd0, 12'd50);
    // nothing at or below the head
    send_beat(ACT_ADD, 12'd180, 12'd0);
    send_beat(ACT_RUN, 12'd0, 12'd5);
    // full store, a dropped request, head past the top track
    for (int i = 0; i < QDEPTH + 1; i++)
      send_beat(ACT_ADD, (i == 0) ? 12'd0 : (i == 1) ? 12'd4095 : track_t'($urandom), 12'd0);
    send_beat(ACT_RUN, 12'd0, 12'd4095);

    random_block(13'd4096, 24);
    random_block(13'd2, 24);
    send_idle_pct  = 57;
    recv_stall_pct = 12;
    random_block(13'd8191, 24);
    random_block(13'd200, 24);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    settle_path();
    long_hold = 1'b1;
    random_block(13'($urandom_range(TC_MAX, TC_MIN)), 24);
    random_block(13'd1, 24);
    settle_path();

    if (board.mismatches == 0 && board.path_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/cscan_pkg.sv
rtl/core/cscan_ctrl.sv
rtl/core/cscan_dp.sv
rtl/core/cscan_disk_seek_scheduler.sv
bench/tb_cscan_disk_seek_scheduler.sv
